@@ src/oss_pkg.sv @@
// Shared types, constants and codes for the order sampling selector.
// No dependencies; every other file but oss_ram imports this package.
`default_nettype none
package oss_pkg;

  // Field widths
  localparam int PROB_W   = 32;
  localparam int DRAW_W   = 32;
  localparam int UIDX_W   = 7;
  localparam int STAT_W   = 2;
  localparam int KEY_W    = 64;
  localparam int SUM_W    = 37;
  localparam int CLS_W    = 2;
  localparam int NUM_W    = 62;
  localparam int DSTEP_W  = 6;
  localparam int DEF_MAX_UNITS = 64;

  // Fixed-point constants (Q2.30)
  localparam logic [SUM_W-1:0] HALF_Q30 = SUM_W'(64'h2000_0000);
  localparam logic [30:0]      ONE_Q30  = 31'h4000_0000;

  // Unit classes
  localparam logic [CLS_W-1:0] CLS_EXCLUDED = 2'd0;
  localparam logic [CLS_W-1:0] CLS_VALID    = 2'd1;
  localparam logic [CLS_W-1:0] CLS_CERTAIN  = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FEW   = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_OVER  = 2'd3;

  // Register index
  localparam logic REG_KEY_MODE = 1'b0;

  typedef struct packed {
    logic [PROB_W-1:0] inclusion_prob;
    logic [DRAW_W-1:0] uniform_draw;
    logic              last_unit;
  } in_item_t;

  typedef struct packed {
    logic [UIDX_W-1:0] unit_index;
    logic [STAT_W-1:0] status;
    logic              final_result;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLASSIFY, S_MUL_NUM, S_MUL_DEN, S_DIV_INIT, S_DIV, S_WRITE,
    S_EVAL, S_DECIDE, S_ERR_OUT, S_RADIX_SCAN, S_RADIX_BIT, S_EMIT_RD, S_EMIT_CHK
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic mul_num;
    logic mul_den;
    logic div_init;
    logic div_step;
    logic ram_wr;
    logic eval;
    logic scan_start;
    logic scan_step;
    logic radix_bit;
    logic emit_take;
    logic emit_skip;
    logic err_load;
    logic clear;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_key;
    logic pmode;
    logic wr_ok;
    logic last;
    logic div_done;
    logic err;
    logic ns_zero;
    logic scan_done;
    logic sc_end;
    logic bit_last;
    logic take;
    logic out_free;
  } st_t;

endpackage
`default_nettype wire

@@ src/oss_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module oss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ src/oss_ctrl.sv @@
// Sequencer for the order sampling selector: load, key division, radix
// selection and emission. Depends on oss_pkg.
`default_nettype none
module oss_ctrl import oss_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire st_t  st,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CLASSIFY;
        end
      end
      S_CLASSIFY: begin
        if (st.need_key) begin
          state_nxt = st.pmode ? S_MUL_NUM : S_DIV_INIT;
        end else if (st.wr_ok) begin
          state_nxt = S_WRITE;
        end else begin
          state_nxt = st.last ? S_EVAL : S_IDLE;
        end
      end
      S_MUL_NUM: begin
        cmd.mul_num = 1'b1;
        state_nxt   = S_MUL_DEN;
      end
      S_MUL_DEN: begin
        cmd.mul_den = 1'b1;
        state_nxt   = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_done) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.ram_wr = 1'b1;
        state_nxt  = st.last ? S_EVAL : S_IDLE;
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.scan_start = 1'b1;
        if (st.err) begin
          state_nxt = S_ERR_OUT;
        end else if (st.ns_zero) begin
          state_nxt = S_EMIT_RD;
        end else begin
          state_nxt = S_RADIX_SCAN;
        end
      end
      S_ERR_OUT: begin
        if (st.out_free) begin
          cmd.err_load = 1'b1;
          cmd.clear    = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_RADIX_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_done) begin
          state_nxt = S_RADIX_BIT;
        end
      end
      S_RADIX_BIT: begin
        cmd.radix_bit = 1'b1;
        state_nxt     = st.bit_last ? S_EMIT_RD : S_RADIX_SCAN;
      end
      S_EMIT_RD: begin
        if (st.sc_end) begin
          cmd.clear = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_EMIT_CHK;
        end
      end
      S_EMIT_CHK: begin
        if (!st.take) begin
          cmd.emit_skip = 1'b1;
          state_nxt     = S_EMIT_RD;
        end else if (st.out_free) begin
          cmd.emit_take = 1'b1;
          state_nxt     = S_EMIT_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ src/oss_dp.sv @@
// Datapath: run counters, key divider, key store, radix selection and
// the result register. Depends on oss_pkg and oss_ram.
`default_nettype none
module oss_dp import oss_pkg::*; #(
  parameter int MAX_UNITS = DEF_MAX_UNITS
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire cmd_t     cmd,
  input  wire in_item_t in_item,
  input  wire logic     key_mode,
  input  wire logic     out_ready,
  output logic          out_valid,
  output out_item_t     out_item,
  output st_t           st
);

  localparam int IW  = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
  localparam int CW  = $clog2(MAX_UNITS + 1);
  localparam int KW  = KEY_W + IW;
  localparam int BW  = $clog2(KW);
  localparam int RW  = CLS_W + KEY_W;

  // Unit capture
  logic [PROB_W-1:0] p_r;
  logic [DRAW_W-1:0] u_r;
  logic              last_r, pmode_r, wr_ok_r;
  logic [CLS_W-1:0]  cls_r;
  logic [IW-1:0]     wr_addr_r;

  // Run counters
  logic [CW-1:0]    unit_cnt_r, cert_cnt_r, val_cnt_r;
  logic [SUM_W-1:0] sum_r;
  logic             ovf_r;

  // Divider
  logic [NUM_W-1:0]   num_r, den_r, rem_r;
  logic [KEY_W-1:0]   quo_r;
  logic               sat_r;
  logic [DSTEP_W-1:0] dcnt_r;

  // Selection
  logic [CW-1:0]   k_r, cnt_c_r, sc_r;
  logic [CW:0]     total_r, emit_cnt_r;
  logic            ns_zero_r, err_r, dv_r;
  logic [STAT_W-1:0] err_code_r;
  logic [KW-1:0]   thr_r;
  logic [BW-1:0]   bit_r;
  logic [IW-1:0]   idx_d_r;

  // Result register
  logic      out_valid_r;
  out_item_t out_item_r;

  // Key store: class and key per unit
  logic          ram_we;
  logic [RW-1:0] ram_wdata, ram_rdata;
  logic [CLS_W-1:0] rd_cls;
  logic [KEY_W-1:0] rd_key;

  assign ram_we    = cmd.ram_wr;
  assign ram_wdata = {cls_r, sat_r ? {KEY_W{1'b1}} : quo_r};
  assign rd_cls    = ram_rdata[RW-1:KEY_W];
  assign rd_key    = ram_rdata[KEY_W-1:0];

  oss_ram #(.WIDTH(RW), .DEPTH(MAX_UNITS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr_r),
    .wdata (ram_wdata),
    .raddr (sc_r[IW-1:0]),
    .rdata (ram_rdata)
  );

  // Shared multiplier for the Pareto numerator and denominator
  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] mul_p;
  always_comb begin
    if (cmd.mul_den) begin
      mul_a = 33'h1_0000_0000 - {1'b0, u_r};
      mul_b = {2'b00, p_r[29:0]};
    end else begin
      mul_a = {1'b0, u_r};
      mul_b = {1'b0, ONE_Q30 - {1'b0, p_r[29:0]}};
    end
    mul_p = {32'b0, mul_a} * {33'b0, mul_b};
  end

  // One restoring division step
  logic [NUM_W:0] dtrial;
  logic           dge;
  assign dtrial = {rem_r, quo_r[KEY_W-1]};
  assign dge    = dtrial >= {1'b0, den_r};

  // Sample size from the rounded valid sum
  logic [SUM_W-1:0] sum_rnd;
  logic [CW-1:0]    ns_w;
  assign sum_rnd = sum_r + HALF_Q30;
  assign ns_w    = sum_rnd[30 +: CW];

  // Radix pass match: prefix above the current bit equal, current bit zero
  logic [KW-1:0] hi_mask, rd_comb;
  logic          match;
  assign hi_mask = ({KW{1'b1}} << bit_r) << 1;
  assign rd_comb = {rd_key, idx_d_r};
  assign match   = (((rd_comb ^ thr_r) & hi_mask) == '0) && !rd_comb[bit_r];

  logic sc_end;
  assign sc_end = (sc_r == unit_cnt_r);

  // Capture and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_cnt_r <= '0;
      cert_cnt_r <= '0;
      val_cnt_r  <= '0;
      sum_r      <= '0;
      ovf_r      <= 1'b0;
      wr_ok_r    <= 1'b0;
      last_r     <= 1'b0;
      cls_r      <= CLS_EXCLUDED;
    end else if (cmd.clear) begin
      unit_cnt_r <= '0;
      cert_cnt_r <= '0;
      val_cnt_r  <= '0;
      sum_r      <= '0;
      ovf_r      <= 1'b0;
    end else if (cmd.load) begin
      last_r <= in_item.last_unit;
      if (unit_cnt_r == CW'(MAX_UNITS)) begin
        ovf_r   <= 1'b1;
        wr_ok_r <= 1'b0;
      end else begin
        wr_ok_r    <= 1'b1;
        unit_cnt_r <= unit_cnt_r + 1'b1;
        if (in_item.inclusion_prob[31:30] != 2'b00) begin
          cls_r      <= CLS_CERTAIN;
          cert_cnt_r <= cert_cnt_r + 1'b1;
        end else if (in_item.inclusion_prob == '0) begin
          cls_r <= CLS_EXCLUDED;
        end else begin
          cls_r     <= CLS_VALID;
          val_cnt_r <= val_cnt_r + 1'b1;
          sum_r     <= sum_r + SUM_W'(in_item.inclusion_prob);
        end
      end
    end
  end

  // Payload captured with each item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p_r       <= in_item.inclusion_prob;
      u_r       <= in_item.uniform_draw;
      pmode_r   <= key_mode;
      wr_addr_r <= unit_cnt_r[IW-1:0];
    end
  end

  // Key division: SPS u*2^30/p, Pareto num*2^32/den with saturation
  always_ff @(posedge clk) begin
    if (cmd.mul_num) begin
      num_r <= mul_p[NUM_W-1:0];
    end
    if (cmd.mul_den) begin
      den_r <= mul_p[NUM_W-1:0];
    end
    if (cmd.div_init) begin
      dcnt_r <= '0;
      if (pmode_r) begin
        rem_r <= {32'b0, num_r[NUM_W-1:32]};
        quo_r <= {num_r[31:0], 32'b0};
        sat_r <= {2'b00, num_r[NUM_W-1:32]} >= den_r[31:0] && den_r[NUM_W-1:32] == '0;
      end else begin
        rem_r <= '0;
        quo_r <= {2'b00, u_r, 30'b0};
        den_r <= {32'b0, p_r[29:0]};
        sat_r <= 1'b0;
      end
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r + 1'b1;
      rem_r  <= dge ? NUM_W'(dtrial - {1'b0, den_r}) : dtrial[NUM_W-1:0];
      quo_r  <= {quo_r[KEY_W-2:0], dge};
    end
  end

  // Evaluation, radix selection and emission scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r      <= 1'b0;
      ns_zero_r  <= 1'b0;
      sc_r       <= '0;
      dv_r       <= 1'b0;
      emit_cnt_r <= '0;
    end else begin
      if (cmd.eval) begin
        k_r        <= ns_w;
        ns_zero_r  <= (ns_w == '0);
        total_r    <= {1'b0, cert_cnt_r} + {1'b0, ns_w};
        thr_r      <= '0;
        bit_r      <= BW'(KW - 1);
        emit_cnt_r <= '0;
        if (ovf_r) begin
          err_r      <= 1'b1;
          err_code_r <= ST_OVER;
        end else if (ns_w > val_cnt_r) begin
          err_r      <= 1'b1;
          err_code_r <= ST_FEW;
        end else if (cert_cnt_r == '0 && ns_w == '0) begin
          err_r      <= 1'b1;
          err_code_r <= ST_EMPTY;
        end else begin
          err_r      <= 1'b0;
          err_code_r <= ST_OK;
        end
      end
      if (cmd.scan_start || cmd.radix_bit) begin
        sc_r    <= '0;
        dv_r    <= 1'b0;
        cnt_c_r <= '0;
      end
      if (cmd.scan_step) begin
        if (!sc_end) begin
          sc_r <= sc_r + 1'b1;
        end
        dv_r    <= !sc_end;
        idx_d_r <= sc_r[IW-1:0];
        if (dv_r && rd_cls == CLS_VALID && match) begin
          cnt_c_r <= cnt_c_r + 1'b1;
        end
      end
      if (cmd.radix_bit) begin
        if (k_r > cnt_c_r) begin
          thr_r[bit_r] <= 1'b1;
          k_r          <= k_r - cnt_c_r;
        end
        bit_r <= bit_r - 1'b1;
      end
      if (cmd.emit_take || cmd.emit_skip) begin
        sc_r <= sc_r + 1'b1;
      end
      if (cmd.emit_take) begin
        emit_cnt_r <= emit_cnt_r + 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_take || cmd.err_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_take) begin
      out_item_r.unit_index   <= UIDX_W'(sc_r) + 1'b1;
      out_item_r.status       <= ST_OK;
      out_item_r.final_result <= (emit_cnt_r + 1'b1) == total_r;
    end else if (cmd.err_load) begin
      out_item_r.unit_index   <= '0;
      out_item_r.status       <= err_code_r;
      out_item_r.final_result <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Status back to the sequencer
  always_comb begin
    st.need_key  = wr_ok_r && cls_r == CLS_VALID;
    st.pmode     = pmode_r;
    st.wr_ok     = wr_ok_r;
    st.last      = last_r;
    st.div_done  = dcnt_r == {DSTEP_W{1'b1}};
    st.err       = err_r;
    st.ns_zero   = ns_zero_r;
    st.scan_done = sc_end && !dv_r;
    st.sc_end    = sc_end;
    st.bit_last  = bit_r == '0;
    st.take      = rd_cls == CLS_CERTAIN ||
                   (rd_cls == CLS_VALID && !ns_zero_r &&
                    {rd_key, sc_r[IW-1:0]} <= thr_r);
    st.out_free  = !out_valid_r || out_ready;
  end

endmodule
`default_nettype wire

@@ src/order_sampling_selector.sv @@
// Order sampling selector (sequential Poisson / Pareto) top level:
// key_mode register, sequencer and datapath. Depends on oss_pkg,
// oss_ctrl, oss_dp and oss_ram.
//
// Use: units stream in on the in_ channel, one item per unit, the final
// unit flagged by last_unit. A valid unit's key comes from a restoring
// divider producing one quotient bit per cycle; the next unit is taken
// only once the current one is stored or dropped.
// in_ready is high only while the sequencer waits for a unit.
// After the last unit the block selects the sample by radix selection over
// key and index: (64 + log2(MAX_UNITS)) passes over the key store; then
// one scan emits selected 1-based indices in ascending order, the last
// flagged by final_result, or one status item when the run fails.
// Results sit in an output register; a stalled receiver holds the scan,
// nothing is lost. Reset (rst_n low, synchronous) clears the run and sets
// key_mode to SPS. key_mode is written through the APB port at address 0
// and is sampled as each unit is loaded.
`default_nettype none
module order_sampling_selector import oss_pkg::*; #(
  parameter int MAX_UNITS = DEF_MAX_UNITS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_item,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic key_mode_r;
  cmd_t cmd;
  st_t  st;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_mode_r <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == REG_KEY_MODE) begin
      key_mode_r <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_KEY_MODE) ? {31'b0, key_mode_r} : '0;

  oss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  oss_dp #(.MAX_UNITS(MAX_UNITS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .key_mode  (key_mode_r),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item),
    .st        (st)
  );

endmodule
`default_nettype wire

@@ src/oss_checker.sv @@
// Port-level checks for order_sampling_selector, bound to the top level.
// Depends on oss_pkg.
`default_nettype none
module oss_checker import oss_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_item,
  input wire logic      pready
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed under stall");

  // Failure status comes alone, index zero, flagged final
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != ST_OK |->
      out_item.unit_index == '0 && out_item.final_result)
    else $error("bad status item");

  // Selected units carry a 1-based index
  a_ok_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == ST_OK |-> out_item.unit_index != '0)
    else $error("zero index on ok item");

  // Reset empties the result register
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind order_sampling_selector oss_checker u_oss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item),
  .pready    (pready)
);
`default_nettype wire

@@ tb/order_sampling_selector_tb.sv @@
// Testbench for the order sampling selector: directed and random populations
// in both key modes, with results checked against an in-bench selection model.
// Depends on oss_pkg and order_sampling_selector.
`default_nettype none
module order_sampling_selector_tb;
  import oss_pkg::*;

  localparam int NUNITS   = 64;
  localparam int WD_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  order_sampling_selector dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // Predictor state for the current population
  logic              mode_q;
  logic [CLS_W-1:0]  cls_q [NUNITS];
  logic [KEY_W-1:0]  key_q [NUNITS];
  int unsigned       held_cnt, certain_cnt, valid_cnt;
  logic [SUM_W-1:0]  prob_sum;
  logic              overflowed;
  out_item_t         sample_q[$];

  int   fail_cnt = 0;
  bit   tail_quiet = 1'b0;
  bit   hold_rx = 1'b0;
  int   idle_cycles = 0;

  // Sequential Poisson key u/p, Q32.32
  function automatic logic [KEY_W-1:0] sps_key(logic [31:0] p, logic [31:0] u);
    logic [63:0] num;
    num = {u, 30'b0};
    return num / {32'b0, p};
  endfunction

  // Pareto odds-ratio key, saturating at 2^32
  function automatic logic [KEY_W-1:0] pareto_key(logic [31:0] p, logic [31:0] u);
    logic [127:0] num, den, q;
    num = {96'b0, u} * (128'h4000_0000 - {96'b0, p});
    den = {96'b0, p} * (128'h1_0000_0000 - {96'b0, u});
    q = (num << 32) / den;
    if ((num / den) > 128'hFFFF_FFFF) return '1;
    return q[63:0];
  endfunction

  function automatic void clear_population();
    held_cnt = 0; certain_cnt = 0; valid_cnt = 0;
    prob_sum = '0; overflowed = 1'b0;
  endfunction

  function automatic void push_status(logic [STAT_W-1:0] st);
    out_item_t r;
    r.unit_index = '0; r.status = st; r.final_result = 1'b1;
    sample_q.push_back(r);
  endfunction

  // Classify one accepted unit; on the last one, queue the selected indices or a status item
  function automatic void select_units(in_item_t it);
    int unsigned ns, rank, nsel;
    out_item_t r;
    if (held_cnt >= NUNITS) begin
      overflowed = 1'b1;
    end else begin
      key_q[held_cnt] = '0;
      if (it.inclusion_prob >= 32'h4000_0000) begin
        cls_q[held_cnt] = CLS_CERTAIN; certain_cnt++;
      end else if (it.inclusion_prob == 0) begin
        cls_q[held_cnt] = CLS_EXCLUDED;
      end else begin
        cls_q[held_cnt] = CLS_VALID;
        key_q[held_cnt] = mode_q ? pareto_key(it.inclusion_prob, it.uniform_draw)
                                 : sps_key(it.inclusion_prob, it.uniform_draw);
        valid_cnt++;
        prob_sum += SUM_W'(it.inclusion_prob);
      end
      held_cnt++;
    end
    if (!it.last_unit) return;
    ns = 32'((prob_sum + HALF_Q30) >> 30);
    nsel = 0;
    if (overflowed) push_status(ST_OVER);
    else if (ns > valid_cnt) push_status(ST_FEW);
    else if (certain_cnt + ns == 0) push_status(ST_EMPTY);
    else begin
      for (int i = 0; i < held_cnt; i++) begin
        bit take;
        take = (cls_q[i] == CLS_CERTAIN);
        if (cls_q[i] == CLS_VALID) begin
          rank = 0;
          for (int j = 0; j < held_cnt; j++)
            if (cls_q[j] == CLS_VALID && j != i &&
                (key_q[j] < key_q[i] || (key_q[j] == key_q[i] && j < i)))
              rank++;
          take = (rank < ns);
        end
        if (take) begin
          r.unit_index = UIDX_W'(i + 1); r.status = ST_OK; r.final_result = 1'b0;
          sample_q.push_back(r);
          nsel++;
        end
      end
      if (nsel == 0) push_status(ST_EMPTY);
      else sample_q[sample_q.size()-1].final_result = 1'b1;
    end
    clear_population();
  endfunction

  // Random idle burst, unless the tail of the run is quiet
  task automatic idle_burst();
    if (!tail_quiet && $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(15, 1)) @(posedge clk);
    end
  endtask

  // Offer one unit and wait for it to be taken
  task automatic send_unit(logic [31:0] p, logic [31:0] u, logic last);
    in_item_t it;
    it.inclusion_prob = p; it.uniform_draw = u; it.last_unit = last;
    idle_burst();
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    select_units(it);
  endtask

  // Wait for the sample to drain, then for the block to settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sample_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_key_mode(logic m);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'(4 * REG_KEY_MODE);
    pwdata <= {31'b0, m};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    mode_q = m;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_prob();
    case ($urandom_range(9))
      0: return 32'h0;
      1: return $urandom_range(32'hFFFF_FFFF, 32'h4000_0000);
      2: return 32'h3FFF_FFFF;
      3: return 32'h1;
      default: return $urandom_range(32'h3FFF_FFFF, 32'h0100_0000) >> $urandom_range(3);
    endcase
  endfunction

  // One random population, mostly small
  task automatic random_population(int n);
    for (int i = 0; i < n; i++)
      send_unit(rand_prob(), $urandom, i == n - 1);
  endtask

  task automatic test_edge_units();
    send_unit(32'h4000_0000, 32'h0, 1'b0);
    send_unit(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_unit(32'h0, 32'h1234_5678, 1'b0);
    send_unit(32'h2000_0000, 32'hFFFF_FFFF, 1'b0);
    send_unit(32'h2000_0000, 32'h0, 1'b0);
    send_unit(32'h0000_0001, 32'h8000_0000, 1'b1);
    send_unit(32'h3FFF_FFFF, 32'h8000_0000, 1'b0);   // tied keys
    send_unit(32'h2000_0000, 32'h4000_0000, 1'b0);
    send_unit(32'h2000_0000, 32'h4000_0000, 1'b1);
    wait_drained();
  endtask

  task automatic test_status_cases();
    send_unit(32'h0, 32'h0, 1'b1);                     // empty sample
    send_unit(32'h1000_0000, 32'h5, 1'b1);             // rounds to zero: empty
    send_unit(32'h3000_0000, 32'h5, 1'b0);             // sum 1.25 rounds to 1, two valid
    send_unit(32'h2000_0000, 32'h5, 1'b0);
    send_unit(32'h0, 32'h5, 1'b1);
    wait_drained();
  endtask

  task automatic test_overflow();
    for (int i = 0; i < NUNITS + 2; i++)
      send_unit(rand_prob(), $urandom, i == NUNITS + 1);
    wait_drained();
    for (int i = 0; i < NUNITS; i++)                   // exactly full, no drop
      send_unit(i[0] ? 32'h4000_0000 : 32'h3FFF_FFFF, $urandom, i == NUNITS - 1);
    wait_drained();
  endtask

  task automatic test_random_pareto();
    write_key_mode(1'b1);
    test_edge_units();
    repeat (12) random_population($urandom_range(8, 2));
    wait_drained();
  endtask

  // Receiver holds off while two populations are sent
  task automatic test_back_pressure();
    hold_rx = 1'b1;
    random_population(6);
    random_population(4);
    hold_rx = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_sps();
    write_key_mode(1'b0);
    repeat (21) random_population($urandom_range(12, 1));
    wait_drained();
    tail_quiet = 1'b1;
    repeat (4) random_population($urandom_range(6, 2));
    wait_drained();
  endtask

  // Receiver: random stall bursts, one long counted hold when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        out_ready <= 1'b0;
        repeat (2000) @(posedge clk);
        hold_rx = 1'b0;
      end else if (!tail_quiet && $urandom_range(4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(15, 1)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (sample_q.size() == 0) begin
        $error("unexpected result index %0d status %0d", out_item.unit_index,
               out_item.status);
        fail_cnt++;
      end else begin
        out_item_t e;
        e = sample_q.pop_front();
        if (out_item.unit_index !== e.unit_index) begin
          $error("unit_index exp %0d got %0d", e.unit_index, out_item.unit_index);
          fail_cnt++;
        end
        if (out_item.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_item.status);
          fail_cnt++;
        end
        if (out_item.final_result !== e.final_result) begin
          $error("final_result exp %0d got %0d", e.final_result, out_item.final_result);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles with no item accepted
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WD_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    mode_q = 1'b0;
    clear_population();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edge_units();
    test_status_cases();
    test_overflow();
    test_back_pressure();
    test_random_pareto();
    test_random_sps();
    repeat (50) @(posedge clk);
    if (fail_cnt == 0 && sample_q.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire
